// ----- hw/rtl/smal_pkg.sv -----
// Shared types, widths, codes and reset values for the sensor monitor alarm logger.
// No dependencies; imported by every module of the block.
package smal_pkg;

    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int TEMP_W      = 8;
    localparam int LIGHT_W     = 3;
    localparam int LOG_SLOT_W  = 5;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int REC_W       = HOUR_W + MIN_W + SEC_W + TEMP_W + LIGHT_W;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    localparam int LOG_DEPTH_DEF = 32;

    localparam logic [SEC_W-1:0]  SEC_PER_MIN  = SEC_W'(60);
    localparam logic [MIN_W-1:0]  MIN_PER_HOUR = MIN_W'(60);
    localparam logic [HOUR_W-1:0] HOUR_PER_DAY = HOUR_W'(24);
    localparam logic [HOUR_W-1:0] HOUR_MAX     = HOUR_W'(23);
    localparam logic [MIN_W-1:0]  MIN_MAX      = MIN_W'(59);
    localparam logic [SEC_W-1:0]  SEC_MAX      = SEC_W'(59);

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_ACK      = 2'd1,
        FUNC_SET_TIME = 2'd2,
        FUNC_TOGGLE   = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALARM_HOUR      = 3'd0,
        CFG_ALARM_MINUTE    = 3'd1,
        CFG_ALARM_SECOND    = 3'd2,
        CFG_TEMP_THRESHOLD  = 3'd3,
        CFG_LIGHT_THRESHOLD = 3'd4,
        CFG_LOG_ENTRIES     = 3'd5,
        CFG_MONITOR_PERIOD  = 3'd6,
        CFG_ALARM_DURATION  = 3'd7
    } cfg_index_t;

    localparam logic [HOUR_W-1:0]     RST_ALARM_HOUR      = HOUR_W'(12);
    localparam logic [MIN_W-1:0]      RST_ALARM_MINUTE    = '0;
    localparam logic [SEC_W-1:0]      RST_ALARM_SECOND    = '0;
    localparam logic [CFG_DATA_W-1:0] RST_TEMP_THRESHOLD  = CFG_DATA_W'(28);
    localparam logic [LIGHT_W-1:0]    RST_LIGHT_THRESHOLD = LIGHT_W'(4);
    localparam logic [CFG_DATA_W-1:0] RST_LOG_ENTRIES     = CFG_DATA_W'(25);
    localparam logic [CFG_DATA_W-1:0] RST_MONITOR_PERIOD  = CFG_DATA_W'(3);
    localparam logic [CFG_DATA_W-1:0] RST_ALARM_DURATION  = CFG_DATA_W'(5);

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

// ----- hw/rtl/sensor_monitor_alarm_logger_core.sv -----
// Sensor monitor with time-of-day clock, alarm checks and ring log of readings.
// Depends on smal_pkg, smal_log_mem and smal_rem_unit.
//
// A transfer on the input stream is a command: second tick, acknowledge, set time or
// manual alarm toggle. Each command produces exactly one result transfer with the clock,
// last readings, log write info and alarm indicators after the command. Acknowledge, set
// time and toggle go from the time update straight to the result; a tick also runs the
// buzzer check and, with monitoring on, waits on the six-step bit-serial remainder unit
// that tests the seconds count against the monitor period, followed on a zero remainder by
// the log memory read-compare-write. The next command is accepted as soon as the core is
// back in idle, even while the previous result still waits on the output register. Log
// records live in a memory of LOG_DEPTH entries; entries never written read as zero after
// reset, with no clearing pass. Configuration writes are always taken.
module sensor_monitor_alarm_logger_core #(
    parameter int LOG_DEPTH = smal_pkg::LOG_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tdata: temp_sample[7:0], light_sample[10:8], set_hours[15:11],
    //        set_minutes[21:16], set_seconds[27:22], zero[31:28]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [smal_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func[1:0]
    input  logic [smal_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: hours_now[4:0], minutes_now[10:5], seconds_now[16:11], temp_now[24:17],
    //        light_now[27:25], log_write[28], log_slot[33:29], alarm_on[34],
    //        buzzer_on[35], clock_alarm_flag[36], temp_alarm_led[37],
    //        light_alarm_led[38], zero[39]
    output logic [smal_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smal_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [smal_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import smal_pkg::*;

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int INC_W = IDX_W + 1;
    localparam int CMP_W = (INC_W > CFG_DATA_W) ? INC_W : CFG_DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TIME,
        ST_BUZZ,
        ST_REM,
        ST_SAMPLE,
        ST_LOG,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // command payload
    func_t              in_func_reg;
    logic [TEMP_W-1:0]  in_temp_reg;
    logic [LIGHT_W-1:0] in_light_reg;
    logic [HOUR_W-1:0]  in_hours_reg;
    logic [MIN_W-1:0]   in_min_reg;
    logic [SEC_W-1:0]   in_sec_reg;

    // configuration
    logic [HOUR_W-1:0]     alarm_hour_reg;
    logic [MIN_W-1:0]      alarm_minute_reg;
    logic [SEC_W-1:0]      alarm_second_reg;
    logic [CFG_DATA_W-1:0] temp_thr_reg;
    logic [LIGHT_W-1:0]    light_thr_reg;
    logic [CFG_DATA_W-1:0] log_entries_reg;
    logic [CFG_DATA_W-1:0] period_reg;
    logic [CFG_DATA_W-1:0] duration_reg;

    // block state
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [SEC_W-1:0]   second_reg, second_next;
    logic               alarm_active_reg, alarm_active_next;
    logic               sensors_en_reg, sensors_en_next;
    logic [TEMP_W-1:0]  last_temp_reg, last_temp_next;
    logic [LIGHT_W-1:0] last_light_reg, last_light_next;
    logic [IDX_W-1:0]   write_slot_reg, write_slot_next;
    logic [IDX_W-1:0]   last_slot_reg, last_slot_next;
    logic [SEC_W-1:0]   buz_end_reg, buz_end_next;
    logic               buz_end_valid_reg, buz_end_valid_next;
    logic               buzzer_high_reg, buzzer_high_next;
    logic               clock_flag_reg, clock_flag_next;
    logic               temp_led_reg, temp_led_next;
    logic               light_led_reg, light_led_next;
    logic               logged_reg, logged_next;
    logic [IDX_W-1:0]   slot_out_reg, slot_out_next;

    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;

    // datapath
    logic               in_accept;
    logic [SEC_W-1:0]   sec_inc;
    logic [MIN_W-1:0]   min_inc;
    logic [HOUR_W-1:0]  hour_inc;
    logic [SEC_W:0]     end_sum;
    logic [SEC_W:0]     end_once;
    logic [SEC_W:0]     end_twice;
    logic               clock_hit;
    logic               temp_ge;
    logic               light_le;
    logic               log_diff;
    logic [INC_W-1:0]   slot_inc;
    logic               slot_wrap;
    logic [REC_W-1:0]   rec_wr;
    logic [REC_W-1:0]   rec_rd;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic               rem_start;
    rem_status_t        rem_status;

    smal_log_mem #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (rec_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (last_slot_reg),
        .rd_data (rec_rd)
    );

    smal_rem_unit u_rem_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (second_reg),
        .divisor  (period_reg),
        .status   (rem_status)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign sec_inc  = second_reg + 1'b1;
    assign min_inc  = minute_reg + 1'b1;
    assign hour_inc = hour_reg + 1'b1;

    assign end_sum   = {1'b0, second_reg} + {1'b0, duration_reg};
    assign end_once  = (end_sum >= {1'b0, SEC_PER_MIN}) ? end_sum - {1'b0, SEC_PER_MIN}
                                                         : end_sum;
    assign end_twice = (end_once >= {1'b0, SEC_PER_MIN}) ? end_once - {1'b0, SEC_PER_MIN}
                                                          : end_once;

    assign clock_hit = (hour_reg >= alarm_hour_reg) &&
                       ((minute_reg >= alarm_minute_reg) || (second_reg >= alarm_second_reg));
    assign temp_ge   = (last_temp_reg >= TEMP_W'(temp_thr_reg));
    assign light_le  = (last_light_reg <= light_thr_reg);

    assign rec_wr   = {hour_reg, minute_reg, second_reg, last_temp_reg, last_light_reg};
    assign log_diff = (rec_rd[LIGHT_W +: TEMP_W] != last_temp_reg) ||
                      (rec_rd[LIGHT_W-1:0] != last_light_reg);

    assign slot_inc  = {1'b0, write_slot_reg} + 1'b1;
    assign slot_wrap = (CMP_W'(slot_inc) >= CMP_W'(log_entries_reg)) ||
                       (slot_inc >= INC_W'(LOG_DEPTH));

    assign mem_rd_en = (state_reg == ST_BUZZ);
    assign mem_wr_en = (state_reg == ST_LOG) && log_diff;
    assign rem_start = (state_reg == ST_BUZZ) && (period_reg != '0);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next         = state_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        alarm_active_next  = alarm_active_reg;
        sensors_en_next    = sensors_en_reg;
        last_temp_next     = last_temp_reg;
        last_light_next    = last_light_reg;
        write_slot_next    = write_slot_reg;
        last_slot_next     = last_slot_reg;
        buz_end_next       = buz_end_reg;
        buz_end_valid_next = buz_end_valid_reg;
        buzzer_high_next   = buzzer_high_reg;
        clock_flag_next    = clock_flag_reg;
        temp_led_next      = temp_led_reg;
        light_led_next     = light_led_reg;
        logged_next        = logged_reg;
        slot_out_next      = slot_out_reg;
        out_valid_next     = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_TIME;
                end
            end
            ST_TIME:
            begin
                logged_next   = 1'b0;
                slot_out_next = '0;
                state_next    = ST_DONE;
                unique case (in_func_reg)
                    FUNC_TICK:
                    begin
                        state_next = ST_BUZZ;
                        if (sec_inc >= SEC_PER_MIN)
                        begin
                            second_next = '0;
                            if (min_inc >= MIN_PER_HOUR)
                            begin
                                minute_next = '0;
                                hour_next   = (hour_inc >= HOUR_PER_DAY) ? '0 : hour_inc;
                            end
                            else
                            begin
                                minute_next = min_inc;
                            end
                        end
                        else
                        begin
                            second_next = sec_inc;
                        end
                    end
                    FUNC_ACK:
                    begin
                        if (alarm_active_reg)
                        begin
                            alarm_active_next = 1'b0;
                            sensors_en_next   = 1'b1;
                            clock_flag_next   = 1'b0;
                        end
                    end
                    FUNC_SET_TIME:
                    begin
                        hour_next   = (in_hours_reg > HOUR_MAX) ? HOUR_MAX : in_hours_reg;
                        minute_next = (in_min_reg > MIN_MAX) ? MIN_MAX : in_min_reg;
                        second_next = (in_sec_reg > SEC_MAX) ? SEC_MAX : in_sec_reg;
                    end
                    FUNC_TOGGLE:
                    begin
                        alarm_active_next = !alarm_active_reg;
                        sensors_en_next   = alarm_active_reg;
                    end
                endcase
            end
            ST_BUZZ:
            begin
                if (buz_end_valid_reg && (buz_end_reg == second_reg))
                begin
                    buz_end_valid_next = 1'b0;
                    buzzer_high_next   = 1'b0;
                end
                state_next = (period_reg != '0) ? ST_REM : ST_DONE;
            end
            ST_REM:
            begin
                if (rem_status.done)
                begin
                    state_next = rem_status.zero ? ST_SAMPLE : ST_DONE;
                end
            end
            ST_SAMPLE:
            begin
                if (sensors_en_reg)
                begin
                    last_temp_next  = in_temp_reg;
                    last_light_next = in_light_reg;
                end
                state_next = ST_LOG;
            end
            ST_LOG:
            begin
                if (log_diff)
                begin
                    last_slot_next  = write_slot_reg;
                    logged_next     = 1'b1;
                    slot_out_next   = write_slot_reg;
                    write_slot_next = slot_wrap ? '0 : IDX_W'(slot_inc);
                end
                if (sensors_en_reg)
                begin
                    if (clock_hit)
                    begin
                        clock_flag_next = 1'b1;
                    end
                    temp_led_next  = temp_ge;
                    light_led_next = light_le;
                end
                if (!sensors_en_reg || clock_hit || temp_ge || light_le)
                begin
                    buz_end_next       = SEC_W'(end_twice);
                    buz_end_valid_next = 1'b1;
                    buzzer_high_next   = 1'b1;
                    alarm_active_next  = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            hour_reg          <= '0;
            minute_reg        <= '0;
            second_reg        <= '0;
            alarm_active_reg  <= 1'b0;
            sensors_en_reg    <= 1'b1;
            last_temp_reg     <= '0;
            last_light_reg    <= '0;
            write_slot_reg    <= '0;
            last_slot_reg     <= '0;
            buz_end_reg       <= '0;
            buz_end_valid_reg <= 1'b0;
            buzzer_high_reg   <= 1'b0;
            clock_flag_reg    <= 1'b0;
            temp_led_reg      <= 1'b0;
            light_led_reg     <= 1'b0;
            logged_reg        <= 1'b0;
            slot_out_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            hour_reg          <= hour_next;
            minute_reg        <= minute_next;
            second_reg        <= second_next;
            alarm_active_reg  <= alarm_active_next;
            sensors_en_reg    <= sensors_en_next;
            last_temp_reg     <= last_temp_next;
            last_light_reg    <= last_light_next;
            write_slot_reg    <= write_slot_next;
            last_slot_reg     <= last_slot_next;
            buz_end_reg       <= buz_end_next;
            buz_end_valid_reg <= buz_end_valid_next;
            buzzer_high_reg   <= buzzer_high_next;
            clock_flag_reg    <= clock_flag_next;
            temp_led_reg      <= temp_led_next;
            light_led_reg     <= light_led_next;
            logged_reg        <= logged_next;
            slot_out_reg      <= slot_out_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hour_reg   <= RST_ALARM_HOUR;
            alarm_minute_reg <= RST_ALARM_MINUTE;
            alarm_second_reg <= RST_ALARM_SECOND;
            temp_thr_reg     <= RST_TEMP_THRESHOLD;
            light_thr_reg    <= RST_LIGHT_THRESHOLD;
            log_entries_reg  <= RST_LOG_ENTRIES;
            period_reg       <= RST_MONITOR_PERIOD;
            duration_reg     <= RST_ALARM_DURATION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ALARM_HOUR:      alarm_hour_reg   <= HOUR_W'(cfg_data);
                CFG_ALARM_MINUTE:    alarm_minute_reg <= cfg_data;
                CFG_ALARM_SECOND:    alarm_second_reg <= cfg_data;
                CFG_TEMP_THRESHOLD:  temp_thr_reg     <= cfg_data;
                CFG_LIGHT_THRESHOLD: light_thr_reg    <= LIGHT_W'(cfg_data);
                CFG_LOG_ENTRIES:     log_entries_reg  <= cfg_data;
                CFG_MONITOR_PERIOD:  period_reg       <= cfg_data;
                CFG_ALARM_DURATION:  duration_reg     <= cfg_data;
                default:             period_reg       <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_func_reg  <= func_t'(s_axis_tuser[1:0]);
            in_temp_reg  <= s_axis_tdata[7:0];
            in_light_reg <= s_axis_tdata[10:8];
            in_hours_reg <= s_axis_tdata[15:11];
            in_min_reg   <= s_axis_tdata[21:16];
            in_sec_reg   <= s_axis_tdata[27:22];
        end
        if (out_load)
        begin
            out_data_reg <= {1'b0,
                             light_led_reg,
                             temp_led_reg,
                             clock_flag_reg,
                             buzzer_high_reg,
                             alarm_active_reg,
                             LOG_SLOT_W'(slot_out_reg),
                             logged_reg,
                             last_light_reg,
                             last_temp_reg,
                             second_reg,
                             minute_reg,
                             hour_reg};
        end
    end

endmodule

// ----- hw/rtl/smal_log_mem.sv -----
// Log record store: one-write, one-read synchronous memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero. Uses smal_pkg.
module smal_log_mem #(
    parameter int LOG_DEPTH = smal_pkg::LOG_DEPTH_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             wr_en,
    input  logic [((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1)-1:0] wr_addr,
    input  logic [smal_pkg::REC_W-1:0]                       wr_data,
    input  logic                                             rd_en,
    input  logic [((LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1)-1:0] rd_addr,
    output logic [smal_pkg::REC_W-1:0]                       rd_data
);
    import smal_pkg::*;

    logic [REC_W-1:0]     log_mem [LOG_DEPTH];
    logic [LOG_DEPTH-1:0] valid_reg;
    logic [REC_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            log_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= log_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/smal_rem_unit.sv -----
// Bit-serial restoring remainder of the seconds count by the monitor period.
// One quotient bit per cycle. Uses smal_pkg.
module smal_rem_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smal_pkg::SEC_W-1:0]      dividend,
    input  logic [smal_pkg::CFG_DATA_W-1:0] divisor,
    output smal_pkg::rem_status_t        status
);
    import smal_pkg::*;

    localparam int CNT_W = $clog2(SEC_W);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SEC_W-1:0]      num_reg, num_next;
    logic [CFG_DATA_W-1:0] div_reg, div_next;
    logic [CFG_DATA_W-1:0] rem_reg, rem_next;
    logic [CFG_DATA_W:0]   trial;

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        trial       = {rem_reg, num_reg[SEC_W-1]};
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            num_next    = dividend;
            div_next    = divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CFG_DATA_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = CFG_DATA_W'(trial);
            end
            num_next = {num_reg[SEC_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SEC_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for sensor_monitor_alarm_logger_core: drives commands on the input stream,
// predicts each result with a behavioral model of the monitor and compares on the result stream.
// Depends on smal_pkg and the core RTL.
module testbench;
    import smal_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

    typedef struct {
        logic [HOUR_W-1:0]     hours;
        logic [MIN_W-1:0]      minutes;
        logic [SEC_W-1:0]      seconds;
        logic [TEMP_W-1:0]     temp;
        logic [LIGHT_W-1:0]    light;
        logic                  log_write;
        logic [LOG_SLOT_W-1:0] log_slot;
        logic                  alarm_on;
        logic                  buzzer_on;
        logic                  clock_flag;
        logic                  temp_led;
        logic                  light_led;
    } monitor_status_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    monitor_status_t pending_status[$];
    int              failures = 0;
    int              quiet_cycles = 0;
    logic            pace_idle = 1'b1;
    logic [TEMP_W-1:0]  held_temp = '0;
    logic [LIGHT_W-1:0] held_light = '0;

    // predicted registers
    logic [HOUR_W-1:0]     alarm_hour_reg = RST_ALARM_HOUR;
    logic [MIN_W-1:0]      alarm_minute_reg = RST_ALARM_MINUTE;
    logic [SEC_W-1:0]      alarm_second_reg = RST_ALARM_SECOND;
    logic [CFG_DATA_W-1:0] temp_thr_reg = RST_TEMP_THRESHOLD;
    logic [LIGHT_W-1:0]    light_thr_reg = RST_LIGHT_THRESHOLD;
    logic [CFG_DATA_W-1:0] log_entries_reg = RST_LOG_ENTRIES;
    logic [CFG_DATA_W-1:0] period_reg = RST_MONITOR_PERIOD;
    logic [CFG_DATA_W-1:0] duration_reg = RST_ALARM_DURATION;

    // predicted monitor state
    logic [HOUR_W-1:0]     hour_cnt = '0;
    logic [MIN_W-1:0]      min_cnt = '0;
    logic [SEC_W-1:0]      sec_cnt = '0;
    logic                  alarm_active = 1'b0;
    logic                  sensors_on = 1'b1;
    logic [TEMP_W-1:0]     last_temp = '0;
    logic [LIGHT_W-1:0]    last_light = '0;
    logic [LOG_SLOT_W-1:0] wr_slot = '0;
    logic [LOG_SLOT_W-1:0] last_slot = '0;
    logic [SEC_W-1:0]      buzz_end_sec = '0;
    logic                  buzz_end_valid = 1'b0;
    logic                  buzz_high = 1'b0;
    logic                  clock_flag = 1'b0;
    logic                  temp_led = 1'b0;
    logic                  light_led = 1'b0;
    logic [REC_W-1:0]      log_ring [LOG_DEPTH_DEF] = '{default: '0};

    sensor_monitor_alarm_logger_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic advance_monitor_model(input func_t f, input logic [TEMP_W-1:0] temp,
                                         input logic [LIGHT_W-1:0] light,
                                         input logic [HOUR_W-1:0] set_h,
                                         input logic [MIN_W-1:0] set_m,
                                         input logic [SEC_W-1:0] set_s);
        monitor_status_t  st;
        logic [REC_W-1:0] prev;
        int               next_slot;
        int               end_sec;
        logic             hit;
        st.log_write = 1'b0;
        st.log_slot = '0;
        case (f)
            FUNC_TICK:
            begin
                if (sec_cnt >= SEC_MAX)
                begin
                    sec_cnt = '0;
                    if (min_cnt >= MIN_MAX)
                    begin
                        min_cnt = '0;
                        hour_cnt = (hour_cnt >= HOUR_MAX) ? '0 : hour_cnt + 1'b1;
                    end
                    else
                        min_cnt = min_cnt + 1'b1;
                end
                else
                    sec_cnt = sec_cnt + 1'b1;
                if (buzz_end_valid && buzz_end_sec == sec_cnt)
                begin
                    buzz_end_valid = 1'b0;
                    buzz_high = 1'b0;
                end
                if (period_reg != 0 && (int'(sec_cnt) % int'(period_reg)) == 0)
                begin
                    if (sensors_on)
                    begin
                        last_temp = temp;
                        last_light = light;
                    end
                    prev = log_ring[last_slot];
                    if (prev[10:3] != last_temp || prev[2:0] != last_light)
                    begin
                        log_ring[wr_slot] = {hour_cnt, min_cnt, sec_cnt, last_temp, last_light};
                        last_slot = wr_slot;
                        st.log_write = 1'b1;
                        st.log_slot = wr_slot;
                        next_slot = int'(wr_slot) + 1;
                        if (next_slot >= int'(log_entries_reg) || next_slot >= LOG_DEPTH_DEF)
                            wr_slot = '0;
                        else
                            wr_slot = LOG_SLOT_W'(next_slot);
                    end
                    hit = 1'b0;
                    if (sensors_on)
                    begin
                        if (hour_cnt >= alarm_hour_reg &&
                            (min_cnt >= alarm_minute_reg || sec_cnt >= alarm_second_reg))
                        begin
                            clock_flag = 1'b1;
                            hit = 1'b1;
                        end
                        temp_led = (int'(last_temp) >= int'(temp_thr_reg));
                        light_led = (last_light <= light_thr_reg);
                        hit = hit | temp_led | light_led;
                    end
                    if (hit || !sensors_on)
                    begin
                        end_sec = int'(sec_cnt) + int'(duration_reg);
                        while (end_sec >= 60)
                            end_sec -= 60;
                        buzz_end_sec = SEC_W'(end_sec);
                        buzz_end_valid = 1'b1;
                        buzz_high = 1'b1;
                        alarm_active = 1'b1;
                    end
                end
            end
            FUNC_ACK:
            begin
                if (alarm_active)
                begin
                    alarm_active = 1'b0;
                    sensors_on = 1'b1;
                    clock_flag = 1'b0;
                end
            end
            FUNC_SET_TIME:
            begin
                hour_cnt = (set_h > HOUR_MAX) ? HOUR_MAX : set_h;
                min_cnt = (set_m > MIN_MAX) ? MIN_MAX : set_m;
                sec_cnt = (set_s > SEC_MAX) ? SEC_MAX : set_s;
            end
            default:
            begin
                sensors_on = alarm_active;
                alarm_active = ~alarm_active;
            end
        endcase
        st.hours = hour_cnt;
        st.minutes = min_cnt;
        st.seconds = sec_cnt;
        st.temp = last_temp;
        st.light = last_light;
        st.alarm_on = alarm_active;
        st.buzzer_on = buzz_high;
        st.clock_flag = clock_flag;
        st.temp_led = temp_led;
        st.light_led = light_led;
        pending_status.push_back(st);
    endtask

    task automatic send_command(input func_t f, input logic [TEMP_W-1:0] temp,
                                input logic [LIGHT_W-1:0] light,
                                input logic [HOUR_W-1:0] set_h,
                                input logic [MIN_W-1:0] set_m,
                                input logic [SEC_W-1:0] set_s);
        int gap;
        gap = pace_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, set_s, set_m, set_h, light, temp};
        s_axis_tuser <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_monitor_model(f, temp, light, set_h, set_m, set_s);
    endtask

    task automatic send_random_command();
        int    pick;
        func_t f;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            f = FUNC_TICK;
        else if (pick < 83)
            f = FUNC_ACK;
        else if (pick < 91)
            f = FUNC_SET_TIME;
        else
            f = FUNC_TOGGLE;
        // repeated readings exercise the no-log path
        if ($urandom_range(0, 2) != 0)
        begin
            held_temp = ($urandom_range(0, 3) == 0) ? TEMP_W'($urandom_range(0, 255))
                                                    : TEMP_W'($urandom_range(0, 60));
            held_light = LIGHT_W'($urandom_range(0, 7));
        end
        send_command(f, held_temp, held_light, HOUR_W'($urandom_range(0, 31)),
                     MIN_W'($urandom_range(0, 63)), SEC_W'($urandom_range(0, 63)));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_registers(input reg_set_t vals);
        drain_results();
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (cfg_index_t'(i))
                CFG_ALARM_HOUR:      alarm_hour_reg = vals[i][HOUR_W-1:0];
                CFG_ALARM_MINUTE:    alarm_minute_reg = vals[i];
                CFG_ALARM_SECOND:    alarm_second_reg = vals[i];
                CFG_TEMP_THRESHOLD:  temp_thr_reg = vals[i];
                CFG_LIGHT_THRESHOLD: light_thr_reg = vals[i][LIGHT_W-1:0];
                CFG_LOG_ENTRIES:     log_entries_reg = vals[i];
                CFG_MONITOR_PERIOD:  period_reg = vals[i];
                default:             duration_reg = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_status(input logic [OUT_TDATA_W-1:0] data);
        monitor_status_t st;
        if (pending_status.size() == 0)
        begin
            $error("result transfer with no command pending");
            failures++;
        end
        else
        begin
            st = pending_status.pop_front();
            compare_field("hours_now", 32'(st.hours), 32'(data[4:0]));
            compare_field("minutes_now", 32'(st.minutes), 32'(data[10:5]));
            compare_field("seconds_now", 32'(st.seconds), 32'(data[16:11]));
            compare_field("temp_now", 32'(st.temp), 32'(data[24:17]));
            compare_field("light_now", 32'(st.light), 32'(data[27:25]));
            compare_field("log_write", 32'(st.log_write), 32'(data[28]));
            compare_field("log_slot", 32'(st.log_slot), 32'(data[33:29]));
            compare_field("alarm_on", 32'(st.alarm_on), 32'(data[34]));
            compare_field("buzzer_on", 32'(st.buzzer_on), 32'(data[35]));
            compare_field("clock_alarm_flag", 32'(st.clock_flag), 32'(data[36]));
            compare_field("temp_alarm_led", 32'(st.temp_led), 32'(data[37]));
            compare_field("light_alarm_led", 32'(st.light_led), 32'(data[38]));
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = pace_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_status(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed_sequence();
        // default registers: alarm 12:00:00, period 3, duration 5
        send_command(FUNC_ACK, '0, '0, '0, '0, '0);
        send_command(FUNC_TICK, '0, '0, '0, '0, '0);
        send_command(FUNC_SET_TIME, '0, '0, 5'd31, 6'd63, 6'd63);
        // midnight rollover with extreme readings
        send_command(FUNC_TICK, 8'd255, 3'd7, '0, '0, '0);
        send_command(FUNC_ACK, '0, '0, '0, '0, '0);
        send_command(FUNC_SET_TIME, 8'd255, 3'd7, 5'd23, 6'd59, 6'd57);
        send_command(FUNC_TICK, '0, '0, '0, '0, '0);
        send_command(FUNC_TICK, '0, '0, '0, '0, '0);
        send_command(FUNC_TICK, '0, '0, '0, '0, '0);
        send_command(FUNC_TOGGLE, '0, '0, '0, '0, '0);
        send_command(FUNC_TOGGLE, '0, '0, '0, '0, '0);
        // sensors disabled: readings ignored, alarm raised again
        send_command(FUNC_SET_TIME, '0, '0, 5'd12, 6'd0, 6'd1);
        send_command(FUNC_TICK, 8'd200, 3'd3, '0, '0, '0);
        send_command(FUNC_TICK, 8'd200, 3'd3, '0, '0, '0);
        send_command(FUNC_ACK, '0, '0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
            send_command(FUNC_TICK, 8'd27, 3'd5, 5'd31, 6'd63, 6'd63);
        send_command(FUNC_SET_TIME, '0, '0, '0, '0, '0);
        send_command(FUNC_TOGGLE, '0, '0, '0, '0, '0);
    endtask

    task automatic run_random_phase(input reg_set_t vals, input int count, input logic paced);
        program_registers(vals);
        pace_idle = paced;
        for (int i = 0; i < count; i++)
            send_random_command();
    endtask

    task automatic test_register_extremes();
        // zero log entries always reuses slot zero
        run_random_phase('{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 50, 1'b1);
        run_random_phase('{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd0}, 70, 1'b0);
        // all ones: masked hour, duration wrap, period only at second zero
        run_random_phase('{6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63}, 90, 1'b1);
        run_random_phase('{6'd23, 6'd59, 6'd59, 6'd50, 6'd7, 6'd32, 6'd60, 6'd60}, 80, 1'b1);
        run_random_phase('{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd1, 6'd0}, 60, 1'b0);
    endtask

    task automatic test_random_traffic();
        reg_set_t vals;
        for (int phase = 0; phase < 12; phase++)
        begin
            vals[CFG_ALARM_HOUR] = CFG_DATA_W'(($urandom_range(0, 5) == 0)
                                               ? $urandom_range(0, 63)
                                               : $urandom_range(0, 23));
            vals[CFG_ALARM_MINUTE] = CFG_DATA_W'($urandom_range(0, 59));
            vals[CFG_ALARM_SECOND] = CFG_DATA_W'($urandom_range(0, 59));
            vals[CFG_TEMP_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 50));
            vals[CFG_LIGHT_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 7));
            vals[CFG_LOG_ENTRIES] = CFG_DATA_W'(($urandom_range(0, 2) == 0)
                                                ? $urandom_range(1, 32)
                                                : $urandom_range(1, 6));
            vals[CFG_MONITOR_PERIOD] = CFG_DATA_W'(($urandom_range(0, 1) == 0)
                                                   ? $urandom_range(1, 3)
                                                   : $urandom_range(0, 60));
            vals[CFG_ALARM_DURATION] = CFG_DATA_W'(($urandom_range(0, 4) == 0)
                                                   ? $urandom_range(55, 63)
                                                   : $urandom_range(0, 10));
            run_random_phase(vals, 120, (phase % 3) != 2);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequence();
        test_register_extremes();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
